// ===== rtl/core/cpi_pkg.sv =====
package cpi_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = DataW + 1;
  localparam int unsigned ProdW  = DataW + ErrW;
  localparam int unsigned IncW   = ProdW + 7;
  localparam int unsigned AccW   = 32;
  localparam int unsigned SumW   = IncW + 1;
  localparam int unsigned IShift = 15;
  localparam int unsigned ShW    = AccW - IShift;
  localparam int unsigned PropW  = 13;
  localparam int unsigned PreW   = ShW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [PropW-1:0] PropClampHi = 13'sd3000;
  localparam logic signed [PropW-1:0] PropClampLo = -13'sd3000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_INTEG_UPPER = 3'd2,
    CFG_INTEG_LOWER = 3'd3,
    CFG_DRIVE_UPPER = 3'd4,
    CFG_DRIVE_LOWER = 3'd5
  } cpi_cfg_idx_t;

  typedef struct packed {
    logic signed [DataW-1:0] prop_gain;
    logic signed [DataW-1:0] integ_gain;
    logic signed [AccW-1:0]  integ_upper;
    logic signed [AccW-1:0]  integ_lower;
    logic signed [DataW-1:0] drive_upper;
    logic signed [DataW-1:0] drive_lower;
  } cpi_cfg_t;

endpackage

// ===== rtl/core/cpi_cfg_regs.sv =====
module cpi_cfg_regs
  import cpi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cpi_cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= '0;
      cfg.integ_gain  <= '0;
      cfg.integ_upper <= 32'sh7FFF_FFFF;
      cfg.integ_lower <= 32'sh8000_0000;
      cfg.drive_upper <= 16'sh7FFF;
      cfg.drive_lower <= 16'sh8000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:   cfg.prop_gain   <= cfg_data[DataW-1:0];
        CFG_INTEG_GAIN:  cfg.integ_gain  <= cfg_data[DataW-1:0];
        CFG_INTEG_UPPER: cfg.integ_upper <= cfg_data[AccW-1:0];
        CFG_INTEG_LOWER: cfg.integ_lower <= cfg_data[AccW-1:0];
        CFG_DRIVE_UPPER: cfg.drive_upper <= cfg_data[DataW-1:0];
        CFG_DRIVE_LOWER: cfg.drive_lower <= cfg_data[DataW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/cpi_mult.sv =====
module cpi_mult
  import cpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    ld_in,
  input  logic                    ld_prod,
  input  logic signed [DataW-1:0] reference,
  input  logic signed [DataW-1:0] feedback,
  input  cpi_cfg_t                cfg,
  output logic signed [ProdW-1:0] prop_prod,
  output logic signed [ProdW-1:0] integ_prod
);

  logic signed [DataW-1:0] ref_q;
  logic signed [DataW-1:0] fdb_q;
  logic signed [ErrW-1:0]  err;

  always_ff @(posedge clk) begin
    if (ld_in) begin
      ref_q <= reference;
      fdb_q <= feedback;
    end
  end

  // 17-bit error, so the difference never wraps
  assign err = ErrW'(ref_q) - ErrW'(fdb_q);

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      prop_prod  <= ProdW'(cfg.prop_gain) * ProdW'(err);
      integ_prod <= ProdW'(cfg.integ_gain) * ProdW'(err);
    end
  end

endmodule

// ===== rtl/core/cpi_integ.sv =====
module cpi_integ
  import cpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ld_scale,
  input  logic                    ld_acc,
  input  logic signed [ProdW-1:0] prop_prod,
  input  logic signed [ProdW-1:0] integ_prod,
  input  cpi_cfg_t                cfg,
  output logic signed [PropW-1:0] prop_term,
  output logic signed [AccW-1:0]  acc
);

  logic signed [PropW-1:0] up_q;
  logic signed [IncW-1:0]  inc_q;
  logic signed [PropW-1:0] up_next;
  logic signed [IncW-1:0]  inc_next;
  logic signed [IncW-1:0]  ip_ext;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  hi_clamped;
  logic signed [AccW-1:0]  acc_next;

  always_comb begin
    if (prop_prod > ProdW'(PropClampHi)) begin
      up_next = PropClampHi;
    end else if (prop_prod < ProdW'(PropClampLo)) begin
      up_next = PropClampLo;
    end else begin
      up_next = prop_prod[PropW-1:0];
    end
    // times 100 as 64 + 32 + 4
    ip_ext   = IncW'(integ_prod);
    inc_next = (ip_ext <<< 6) + (ip_ext <<< 5) + (ip_ext <<< 2);
  end

  always_ff @(posedge clk) begin
    if (ld_scale) begin
      up_q  <= up_next;
      inc_q <= inc_next;
    end
  end

  // upper bound first, then lower: inverted bounds end at the lower one
  always_comb begin
    sum = SumW'(acc) + SumW'(inc_q);
    if (sum > SumW'(cfg.integ_upper)) begin
      hi_clamped = SumW'(cfg.integ_upper);
    end else begin
      hi_clamped = sum;
    end
    if (hi_clamped < SumW'(cfg.integ_lower)) begin
      acc_next = cfg.integ_lower;
    end else begin
      acc_next = hi_clamped[AccW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ld_acc) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      prop_term <= up_q;
    end
  end

  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    ld_acc |=> (acc <= $past(cfg.integ_upper)) || (acc == $past(cfg.integ_lower)))
    else $error("integral left its clamp window");

  a_acc_holds: assert property (@(posedge clk) disable iff (rst)
    !ld_acc |=> $stable(acc))
    else $error("integral changed without an update");

endmodule

// ===== rtl/core/cpi_drive.sv =====
module cpi_drive
  import cpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ld_out,
  input  logic signed [PropW-1:0] prop_term,
  input  logic signed [AccW-1:0]  acc,
  input  cpi_cfg_t                cfg,
  output logic signed [DataW-1:0] drive
);

  logic signed [ShW-1:0]   ishift;
  logic signed [PreW-1:0]  pre;
  logic signed [DataW-1:0] drive_next;

  always_comb begin
    // floor shift of the integral: keep the top bits
    ishift = acc[AccW-1:IShift];
    pre    = PreW'(prop_term) + PreW'(ishift);
    if (pre > PreW'(cfg.drive_upper)) begin
      drive_next = cfg.drive_upper;
    end else if (pre < PreW'(cfg.drive_lower)) begin
      drive_next = cfg.drive_lower;
    end else begin
      drive_next = pre[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      drive <= drive_next;
    end
  end

  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    ld_out |=> (drive <= $past(cfg.drive_upper)) || (drive == $past(cfg.drive_lower)))
    else $error("drive left its clamp window");

endmodule

// ===== rtl/core/current_pi_controller_core.sv =====
// A beat passes input, product, scale, accumulator and drive registers; a stall holds it.
// Throughput: one beat per cycle while out_stall is low; the integral update is the only
//   feedback loop and closes through acc alone (one 41-bit add and two compares).
// Five stages: input, multiply, clamp and scale, accumulate, drive clamp.
// Reset (rst, synchronous, active high): empty pipeline, integral to zero,
//   gains to zero, clamp bounds to the full range of their widths.
module current_pi_controller_core
  import cpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DataW-1:0] reference,
  input  logic signed [DataW-1:0] feedback,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] drive,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgDataW-1:0]     cfg_data
);

  localparam int unsigned NStg = 5;

  cpi_cfg_t                cfg;
  logic [NStg-1:0]         vld;
  logic [NStg-1:0]         adv;
  logic [NStg-1:0]         ld;
  logic signed [ProdW-1:0] prop_prod;
  logic signed [ProdW-1:0] integ_prod;
  logic signed [PropW-1:0] prop_term;
  logic signed [AccW-1:0]  acc;

  // A stage may advance when it is empty or the stage after it advances.
  // The last stage advances when the output beat is taken or the slot is empty.
  always_comb begin
    adv[NStg-1] = !vld[NStg-1] || !out_stall;
    for (int i = NStg - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
    // load payload only when real data moves in, so a stalled stage holds
    ld[0] = adv[0] && in_valid;
    for (int i = 1; i < NStg; i++) begin
      ld[i] = adv[i] && vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NStg; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NStg-1];

  cpi_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register and the two gain products
  cpi_mult u_mult (
    .clk        (clk),
    .ld_in      (ld[0]),
    .ld_prod    (ld[1]),
    .reference  (reference),
    .feedback   (feedback),
    .cfg        (cfg),
    .prop_prod  (prop_prod),
    .integ_prod (integ_prod)
  );

  // proportional clamp, integral scaling, then the accumulator itself
  cpi_integ u_integ (
    .clk        (clk),
    .rst        (rst),
    .ld_scale   (ld[2]),
    .ld_acc     (ld[3]),
    .prop_prod  (prop_prod),
    .integ_prod (integ_prod),
    .cfg        (cfg),
    .prop_term  (prop_term),
    .acc        (acc)
  );

  // sum and final clamp into the output register
  cpi_drive u_drive (
    .clk       (clk),
    .rst       (rst),
    .ld_out    (ld[4]),
    .prop_term (prop_term),
    .acc       (acc),
    .cfg       (cfg),
    .drive     (drive)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && out_stall) |-> in_stall)
    else $error("full pipeline took a beat under output stall");

  a_drain_out: assert property (@(posedge clk) disable iff (rst)
    (vld[NStg-2] && !vld[NStg-1]) |=> vld[NStg-1])
    else $error("result did not move into an empty output slot");

endmodule
